// ----- hdl/tcs_pkg.sv -----
// Shared types and constants for the task cadence scheduler.
`timescale 1ns / 1ps

package tcs_pkg;

   localparam int NUM_TASKS  = 4;
   localparam int TASK_W     = 2;
   localparam int CADENCE_W  = 32;
   localparam int NOW_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_EYE_CADENCE         = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GEOMETRY_CADENCE    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RECOGNITION_CADENCE = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_OBJECT_CADENCE      = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNCERTAINTY_MASK    = 3'd4;

   localparam logic [CADENCE_W-1:0] EYE_CADENCE_RESET         = 32'd33;
   localparam logic [CADENCE_W-1:0] GEOMETRY_CADENCE_RESET    = 32'd100;
   localparam logic [CADENCE_W-1:0] RECOGNITION_CADENCE_RESET = 32'd500;
   localparam logic [CADENCE_W-1:0] OBJECT_CADENCE_RESET      = 32'd250;
   localparam logic [NUM_TASKS-1:0] UNCERTAINTY_MASK_RESET    = 4'd3;

   typedef enum logic [1:0] {
      OP_EVALUATE = 2'd0,
      OP_MARK     = 2'd1,
      OP_CLEAR    = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REASON_FIRST_RUN      = 3'd0,
      REASON_TIME_BACKWARDS = 3'd1,
      REASON_UNCERTAIN      = 3'd2,
      REASON_CADENCE_ELAPSED = 3'd3,
      REASON_NOT_DUE        = 3'd4
   } reason_type;

   typedef struct packed {
      logic [NUM_TASKS-1:0][CADENCE_W-1:0] cadence;
      logic [NUM_TASKS-1:0]                uncertainty_mask;
   } config_type;

   typedef struct packed {
      logic              mark_we;
      logic              clear_all;
      logic [TASK_W-1:0] task_idx;
   } update_type;

   typedef struct packed {
      logic       run;
      reason_type reason;
      logic       mark_ok;
   } result_type;

endpackage

// ----- hdl/tcs_csr.sv -----
// Configuration registers: per-task cadences and the uncertainty run mask.
`timescale 1ns / 1ps

module tcs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tcs_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [tcs_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output tcs_pkg::config_type                 cfg
);

   tcs_pkg::config_type cfg_ff;
   tcs_pkg::config_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            tcs_pkg::CSR_EYE_CADENCE:         cfg_in.cadence[0] = csr_wdata;
            tcs_pkg::CSR_GEOMETRY_CADENCE:    cfg_in.cadence[1] = csr_wdata;
            tcs_pkg::CSR_RECOGNITION_CADENCE: cfg_in.cadence[2] = csr_wdata;
            tcs_pkg::CSR_OBJECT_CADENCE:      cfg_in.cadence[3] = csr_wdata;
            tcs_pkg::CSR_UNCERTAINTY_MASK: begin
               cfg_in.uncertainty_mask = csr_wdata[tcs_pkg::NUM_TASKS-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cadence[0]       <= tcs_pkg::EYE_CADENCE_RESET;
         cfg_ff.cadence[1]       <= tcs_pkg::GEOMETRY_CADENCE_RESET;
         cfg_ff.cadence[2]       <= tcs_pkg::RECOGNITION_CADENCE_RESET;
         cfg_ff.cadence[3]       <= tcs_pkg::OBJECT_CADENCE_RESET;
         cfg_ff.uncertainty_mask <= tcs_pkg::UNCERTAINTY_MASK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/tcs_track.sv -----
// Per-task run record: last run time and valid mark, with mark and clear updates.
`timescale 1ns / 1ps

module tcs_track #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tcs_pkg::update_type               upd,
   input  logic [TIME_WIDTH-1:0]             upd_time,
   input  logic [tcs_pkg::TASK_W-1:0]        rd_task,
   output logic                              rd_valid,
   output logic [TIME_WIDTH-1:0]             rd_last,
   output logic [tcs_pkg::NUM_TASKS-1:0]     valid_all
);

   logic [tcs_pkg::NUM_TASKS-1:0]                 run_valid_ff;
   logic [tcs_pkg::NUM_TASKS-1:0]                 run_valid_in;
   logic [tcs_pkg::NUM_TASKS-1:0][TIME_WIDTH-1:0] last_time_ff;

   always_comb begin
      run_valid_in = run_valid_ff;
      if (upd.clear_all) begin
         run_valid_in = '0;
      end else if (upd.mark_we) begin
         run_valid_in[upd.task_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_valid_ff <= '0;
      end else begin
         run_valid_ff <= run_valid_in;
      end
   end

   // The time store has no reset; an entry is only read while its mark is set.
   always_ff @(posedge clock) begin
      if (upd.mark_we) begin
         last_time_ff[upd.task_idx] <= upd_time;
      end
   end

   assign rd_valid  = run_valid_ff[rd_task];
   assign rd_last   = last_time_ff[rd_task];
   assign valid_all = run_valid_ff;

endmodule

// ----- hdl/tcs_decide.sv -----
// Decision logic: evaluate reason, mark acceptance and the record update.
`timescale 1ns / 1ps

module tcs_decide #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                              fire,
   input  logic [1:0]                        op,
   input  logic [tcs_pkg::TASK_W-1:0]        task_idx,
   input  logic [TIME_WIDTH-1:0]             now,
   input  logic                              uncertain,
   input  logic                              rd_valid,
   input  logic [TIME_WIDTH-1:0]             rd_last,
   input  tcs_pkg::config_type               cfg,
   output tcs_pkg::result_type               result,
   output tcs_pkg::update_type               upd
);

   localparam int CMP_W = (TIME_WIDTH > tcs_pkg::CADENCE_W) ? TIME_WIDTH : tcs_pkg::CADENCE_W;

   logic                  backwards;
   logic [TIME_WIDTH-1:0] elapsed;
   logic                  due;

   assign backwards = now < rd_last;
   assign elapsed   = now - rd_last;
   assign due       = CMP_W'(elapsed) >= CMP_W'(cfg.cadence[task_idx]);

   always_comb begin
      result        = '0;
      result.reason = tcs_pkg::REASON_FIRST_RUN;
      upd           = '0;
      upd.task_idx  = task_idx;
      case (tcs_pkg::op_type'(op))
         tcs_pkg::OP_EVALUATE: begin
            if (!rd_valid) begin
               result.run    = 1'b1;
               result.reason = tcs_pkg::REASON_FIRST_RUN;
            end else if (backwards) begin
               result.reason = tcs_pkg::REASON_TIME_BACKWARDS;
            end else if (uncertain && cfg.uncertainty_mask[task_idx]) begin
               result.run    = 1'b1;
               result.reason = tcs_pkg::REASON_UNCERTAIN;
            end else if (due) begin
               result.run    = 1'b1;
               result.reason = tcs_pkg::REASON_CADENCE_ELAPSED;
            end else begin
               result.reason = tcs_pkg::REASON_NOT_DUE;
            end
         end
         tcs_pkg::OP_MARK: begin
            result.mark_ok = !(rd_valid && backwards);
            upd.mark_we    = fire && result.mark_ok;
         end
         tcs_pkg::OP_CLEAR: begin
            upd.clear_all = fire;
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ----- hdl/task_cadence_scheduler.sv -----
// Top level of the task cadence scheduler: input stage, decision and result register.
`timescale 1ns / 1ps
//
// The scheduler keeps a last run time and a valid mark for each of four tasks.
// Request words on req_ carry an operation: evaluate gives a run decision and
// its reason, mark records the run time, clear drops every valid mark. Every
// request gives exactly one response word on rsp_.
// A request is registered in the input stage on acceptance and decided from that
// register; the response register loads when the output is free, and rsp_tvalid
// then rises. One word is accepted every cycle while responses are taken; the
// record update and the next word's read meet in the single table register stage.
// When rsp_tready is low the response holds, the input stage fills, and
// req_tready falls until the response is taken.
// csr_ writes set the four cadences and the uncertainty mask; the user must make
// them while no request is in flight, as the block does not enforce this.
// Reset clears all valid marks and both stages and restores the default
// cadences; recorded times are not cleared.
//
module task_cadence_scheduler #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // op [1:0], task_req [3:2], now [35:4], uncertain [36], zero [39:37]
   input  logic [tcs_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // run [0], reason [3:1], mark_ok [4], zero [7:5]
   output logic [tcs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [tcs_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [tcs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   tcs_pkg::config_type cfg;
   tcs_pkg::update_type upd;
   tcs_pkg::result_type result;

   logic                              s1_valid_ff;
   logic                              s1_valid_in;
   logic [1:0]                        s1_op_ff;
   logic [tcs_pkg::TASK_W-1:0]        s1_task_ff;
   logic [TIME_WIDTH-1:0]             s1_now_ff;
   logic                              s1_uncertain_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   tcs_pkg::result_type               rsp_result_ff;

   logic                              out_free;
   logic                              fire;
   logic                              req_fire;
   logic                              rd_valid;
   logic [TIME_WIDTH-1:0]             rd_last;
   logic [tcs_pkg::NUM_TASKS-1:0]     valid_all;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !out_free);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff        <= req_tdata[1:0];
         s1_task_ff      <= req_tdata[3:2];
         s1_now_ff       <= TIME_WIDTH'(req_tdata[35:4]);
         s1_uncertain_ff <= req_tdata[36];
      end
      if (fire) begin
         rsp_result_ff <= result;
      end
   end

   tcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tcs_track #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .upd       (upd),
      .upd_time  (s1_now_ff),
      .rd_task   (s1_task_ff),
      .rd_valid  (rd_valid),
      .rd_last   (rd_last),
      .valid_all (valid_all)
   );

   tcs_decide #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_decide (
      .fire      (fire),
      .op        (s1_op_ff),
      .task_idx  (s1_task_ff),
      .now       (s1_now_ff),
      .uncertain (s1_uncertain_ff),
      .rd_valid  (rd_valid),
      .rd_last   (rd_last),
      .cfg       (cfg),
      .result    (result),
      .upd       (upd)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_result_ff.mark_ok, rsp_result_ff.reason,
                        rsp_result_ff.run};

   a_mark_only_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.mark_ok |->
         !rsp_result_ff.run && rsp_result_ff.reason == tcs_pkg::REASON_FIRST_RUN)
      else $error("mark response carries a run decision");

   a_run_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_result_ff.run |->
         rsp_result_ff.reason == tcs_pkg::REASON_FIRST_RUN ||
         rsp_result_ff.reason == tcs_pkg::REASON_UNCERTAIN ||
         rsp_result_ff.reason == tcs_pkg::REASON_CADENCE_ELAPSED)
      else $error("run decision with a non-running reason");

   a_clear_drops_marks: assert property (@(posedge clock) disable iff (reset)
      upd.clear_all |=> valid_all == '0)
      else $error("valid marks survive a clear");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_now_ff))
      else $error("input stage lost a word under stall");

endmodule
